// ----- rtl/usf_pkg.sv -----
package usf_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_SS   = 2'd1,
        PH_HS   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_START_SS   = 3'd1,
        CMD_START_HS   = 3'd2,
        CMD_RESTART_HS = 3'd3,
        CMD_REPLUG_HS  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_SS_WON      = 4'd1,
        EV_ATTACH      = 4'd2,
        EV_IDLE_RETRY  = 4'd3,
        EV_KEPT_HOST   = 4'd4,
        EV_NO_PARTNER  = 4'd5,
        EV_NOT_ENUM    = 4'd6,
        EV_SS_LOST     = 4'd7,
        EV_BOUNCE_TO   = 4'd8,
        EV_HS_UNPLUG   = 4'd9,
        EV_HS_STAYING  = 4'd10,
        EV_HS_WRITEOFF = 4'd11
    } t_evt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE        = 3'd0,
        CFG_SS_RETRY      = 3'd1,
        CFG_HS_FALLBACK   = 3'd2,
        CFG_SS_TRAIN_MAX  = 3'd3,
        CFG_SS_LOST       = 3'd4,
        CFG_SS_REENUM     = 3'd5,
        CFG_HS_DISCONNECT = 3'd6
    } t_cfg_idx;

    localparam logic [3:0] LS_DISABLED   = 4'd4;
    localparam logic [3:0] LS_RXDETECT   = 4'd5;
    localparam logic [3:0] LS_INACTIVE   = 4'd6;
    localparam logic [3:0] LS_COMPLIANCE = 4'd10;
    localparam logic [3:0] LS_LOOPBACK   = 4'd11;

    localparam logic [CFG_DATA_W-1:0] RST_SS_RETRY      = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_HS_FALLBACK   = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] RST_SS_TRAIN_MAX  = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] RST_SS_LOST       = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] RST_SS_REENUM     = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] RST_HS_DISCONNECT = 16'd2000;

    typedef struct packed {
        logic       tick;
        logic       host_pulldown;
        logic       ss_enumerated;
        logic       ss_link_progress;
        logic [3:0] link_code;
        logic       device_configured;
        logic       hs_suspended;
        logic       hs_bus_reset;
    } t_in;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] command;
        logic [3:0] event_res;
        logic       host_known;
    } t_out;

    typedef struct packed {
        logic                  enable;
        logic [CFG_DATA_W-1:0] ss_retry_ms;
        logic [CFG_DATA_W-1:0] hs_fallback_ms;
        logic [CFG_DATA_W-1:0] ss_train_max_ms;
        logic [CFG_DATA_W-1:0] ss_lost_ms;
        logic [CFG_DATA_W-1:0] ss_reenum_ms;
        logic [CFG_DATA_W-1:0] hs_disconnect_ms;
    } t_cfg;

    function automatic logic link_dead(input logic [3:0] ls);
        return (ls == LS_DISABLED) || (ls == LS_RXDETECT) || (ls == LS_INACTIVE) ||
               (ls == LS_COMPLIANCE) || (ls == LS_LOOPBACK);
    endfunction

    function automatic t_cmd evt_to_cmd(input t_evt ev);
        t_cmd c;
        case (ev)
            EV_ATTACH, EV_IDLE_RETRY, EV_KEPT_HOST, EV_SS_LOST,
            EV_BOUNCE_TO, EV_HS_UNPLUG:    c = CMD_START_SS;
            EV_NO_PARTNER, EV_NOT_ENUM:    c = CMD_START_HS;
            EV_HS_STAYING:                 c = CMD_RESTART_HS;
            EV_HS_WRITEOFF:                c = CMD_REPLUG_HS;
            default:                       c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/usb_speed_fallback_supervisor_top.sv -----
// USB speed fallback supervisor.
// Each input beat is one poll of sampled line and link status; each poll
// yields exactly one result beat with the phase after the poll, a command for
// the SuperSpeed and high-speed controllers, an event code and the known-host
// flag. Both channels use valid and stall; a beat moves on an edge where valid
// is high and stall is low.
// An accepted poll sits in the input register while the decision logic settles
// the supervisor state; the result register is then loaded with the result
// beat. Throughput is one poll per cycle while the receiver does not stall, as
// the decision logic between those two registers is combinational.
// When the receiver stalls, the result register holds its beat and one more
// poll may wait in the input register; input stall rises only when both are
// full and the result is not being taken.
// Configuration is a plain write port (enable, index, 16-bit data); the user
// must write it while no poll is in flight (not enforced). Reset (synchronous,
// active low) restores the default register values, returns to the wait phase
// with all timers and flags cleared, and empties both registers.
module usb_speed_fallback_supervisor_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  usf_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output usf_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [usf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [usf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic          r_in_valid;
    usf_pkg::t_in  r_in_data;
    logic          r_out_valid;
    usf_pkg::t_out r_out_data;
    usf_pkg::t_out core_out;
    usf_pkg::t_cfg cfg;
    logic          advance;
    logic          fire;
    logic          take_in;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    usf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    usf_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_in    (r_in_data),
        .i_cfg   (cfg),
        .o_out   (core_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= core_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/usf_cfg_regs.sv -----
module usf_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [usf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [usf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output usf_pkg::t_cfg                   o_cfg
);

    usf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b1;
            r_cfg.ss_retry_ms      <= usf_pkg::RST_SS_RETRY;
            r_cfg.hs_fallback_ms   <= usf_pkg::RST_HS_FALLBACK;
            r_cfg.ss_train_max_ms  <= usf_pkg::RST_SS_TRAIN_MAX;
            r_cfg.ss_lost_ms       <= usf_pkg::RST_SS_LOST;
            r_cfg.ss_reenum_ms     <= usf_pkg::RST_SS_REENUM;
            r_cfg.hs_disconnect_ms <= usf_pkg::RST_HS_DISCONNECT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                usf_pkg::CFG_ENABLE:        r_cfg.enable           <= i_cfg_data[0];
                usf_pkg::CFG_SS_RETRY:      r_cfg.ss_retry_ms      <= i_cfg_data;
                usf_pkg::CFG_HS_FALLBACK:   r_cfg.hs_fallback_ms   <= i_cfg_data;
                usf_pkg::CFG_SS_TRAIN_MAX:  r_cfg.ss_train_max_ms  <= i_cfg_data;
                usf_pkg::CFG_SS_LOST:       r_cfg.ss_lost_ms       <= i_cfg_data;
                usf_pkg::CFG_SS_REENUM:     r_cfg.ss_reenum_ms     <= i_cfg_data;
                usf_pkg::CFG_HS_DISCONNECT: r_cfg.hs_disconnect_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/usf_core.sv -----
module usf_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  usf_pkg::t_in  i_in,
    input  usf_pkg::t_cfg i_cfg,
    output usf_pkg::t_out o_out
);

    localparam int CW = (TIMER_BITS > usf_pkg::CFG_DATA_W) ? TIMER_BITS : usf_pkg::CFG_DATA_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    usf_pkg::t_phase r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_sub, n_sub, r_attach, n_attach, r_bounce, n_bounce;
    logic r_host_present, n_host_present;
    logic r_dead_seen, n_dead_seen;
    logic r_idle_seen, n_idle_seen;
    logic r_bounced, n_bounced;
    logic r_known, n_known;
    logic r_hs_reset, n_hs_reset;

    logic [TIMER_BITS-1:0] sub_t, attach_t, bounce_t;
    logic dead;
    usf_pkg::t_evt evt;

    function automatic logic ge(input logic [TIMER_BITS-1:0] t,
                                input logic [usf_pkg::CFG_DATA_W-1:0] lim);
        return CW'(t) >= CW'(lim);
    endfunction

    // Timers advance on every tick, enabled or not.
    always_comb begin
        sub_t    = (i_in.tick && r_sub != TMAX)    ? r_sub + 1'b1    : r_sub;
        attach_t = (i_in.tick && r_attach != TMAX) ? r_attach + 1'b1 : r_attach;
        bounce_t = (i_in.tick && r_bounce != TMAX) ? r_bounce + 1'b1 : r_bounce;
        dead     = usf_pkg::link_dead(i_in.link_code);
    end

    // Decision for this beat.
    always_comb begin
        evt = usf_pkg::EV_NONE;
        if (i_cfg.enable) begin
            case (r_phase)
                usf_pkg::PH_WAIT: begin
                    if (i_in.ss_enumerated) begin
                        evt = usf_pkg::EV_SS_WON;
                    end else if (!r_host_present) begin
                        if (i_in.host_pulldown) begin
                            evt = usf_pkg::EV_ATTACH;
                        end else if (ge(sub_t, i_cfg.ss_retry_ms)) begin
                            evt = usf_pkg::EV_IDLE_RETRY;
                        end
                    end else if (i_in.ss_link_progress ? ge(attach_t, i_cfg.ss_train_max_ms)
                                                       : ge(attach_t, i_cfg.hs_fallback_ms)) begin
                        if (r_known) begin
                            evt = usf_pkg::EV_KEPT_HOST;
                        end else if (i_in.ss_link_progress) begin
                            evt = usf_pkg::EV_NOT_ENUM;
                        end else begin
                            evt = usf_pkg::EV_NO_PARTNER;
                        end
                    end
                end
                usf_pkg::PH_SS: begin
                    if (dead) begin
                        if (r_dead_seen && ge(sub_t, i_cfg.ss_lost_ms)) begin
                            evt = usf_pkg::EV_SS_LOST;
                        end
                    end else if (r_bounced && !i_in.device_configured &&
                                 ge(bounce_t, i_cfg.ss_reenum_ms)) begin
                        evt = usf_pkg::EV_BOUNCE_TO;
                    end
                end
                usf_pkg::PH_HS: begin
                    if (i_in.hs_suspended && r_idle_seen && ge(sub_t, i_cfg.hs_disconnect_ms)) begin
                        if (!i_in.host_pulldown) begin
                            evt = usf_pkg::EV_HS_UNPLUG;
                        end else if (r_hs_reset || i_in.hs_bus_reset) begin
                            evt = usf_pkg::EV_HS_STAYING;
                        end else begin
                            evt = usf_pkg::EV_HS_WRITEOFF;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_phase        = r_phase;
        n_sub          = sub_t;
        n_attach       = attach_t;
        n_bounce       = bounce_t;
        n_host_present = r_host_present;
        n_dead_seen    = r_dead_seen;
        n_idle_seen    = r_idle_seen;
        n_bounced      = r_bounced;
        n_known        = r_known;
        n_hs_reset     = r_hs_reset;
        if (i_cfg.enable) begin
            case (r_phase)
                usf_pkg::PH_WAIT: begin
                    if (i_in.ss_enumerated) begin
                        n_known = 1'b1;
                        n_phase = usf_pkg::PH_SS;
                    end else if (!r_host_present) begin
                        if (!i_in.host_pulldown) begin
                            n_known = 1'b0;
                            if (evt == usf_pkg::EV_IDLE_RETRY) begin
                                n_sub = '0;
                            end
                        end else begin
                            n_host_present = 1'b1;
                            n_attach       = '0;
                        end
                    end else if (evt == usf_pkg::EV_KEPT_HOST) begin
                        n_attach = '0;
                    end else if (evt == usf_pkg::EV_NO_PARTNER || evt == usf_pkg::EV_NOT_ENUM) begin
                        n_hs_reset = 1'b0;
                        n_phase    = usf_pkg::PH_HS;
                    end
                end
                usf_pkg::PH_SS: begin
                    if (dead) begin
                        if (!r_bounced) begin
                            n_bounced = 1'b1;
                            n_bounce  = '0;
                        end
                        if (!r_dead_seen) begin
                            n_dead_seen = 1'b1;
                            n_sub       = '0;
                        end else if (evt == usf_pkg::EV_SS_LOST) begin
                            n_phase = usf_pkg::PH_WAIT;
                        end
                    end else begin
                        n_dead_seen = 1'b0;
                        if (r_bounced && i_in.device_configured) begin
                            n_bounced = 1'b0;
                        end
                        if (evt == usf_pkg::EV_BOUNCE_TO) begin
                            n_phase = usf_pkg::PH_WAIT;
                        end
                    end
                end
                usf_pkg::PH_HS: begin
                    if (i_in.hs_bus_reset) begin
                        n_hs_reset = 1'b1;
                    end
                    if (i_in.hs_suspended) begin
                        if (!r_idle_seen) begin
                            n_idle_seen = 1'b1;
                            n_sub       = '0;
                        end else if (evt == usf_pkg::EV_HS_STAYING ||
                                     evt == usf_pkg::EV_HS_WRITEOFF) begin
                            n_idle_seen = 1'b0;
                            n_sub       = '0;
                        end else if (evt == usf_pkg::EV_HS_UNPLUG) begin
                            n_phase = usf_pkg::PH_WAIT;
                        end
                    end else begin
                        n_idle_seen = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            // Any phase change starts the new phase with fresh sub-phase state.
            if (n_phase != r_phase) begin
                n_sub          = '0;
                n_host_present = 1'b0;
                n_dead_seen    = 1'b0;
                n_idle_seen    = 1'b0;
                n_bounced      = 1'b0;
            end
        end
    end

    // Result fields.
    always_comb begin
        o_out.phase      = n_phase;
        o_out.command    = usf_pkg::evt_to_cmd(evt);
        o_out.event_res  = evt;
        o_out.host_known = n_known;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= usf_pkg::PH_WAIT;
            r_sub          <= '0;
            r_attach       <= '0;
            r_bounce       <= '0;
            r_host_present <= 1'b0;
            r_dead_seen    <= 1'b0;
            r_idle_seen    <= 1'b0;
            r_bounced      <= 1'b0;
            r_known        <= 1'b0;
            r_hs_reset     <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_sub          <= n_sub;
            r_attach       <= n_attach;
            r_bounce       <= n_bounce;
            r_host_present <= n_host_present;
            r_dead_seen    <= n_dead_seen;
            r_idle_seen    <= n_idle_seen;
            r_bounced      <= n_bounced;
            r_known        <= n_known;
            r_hs_reset     <= n_hs_reset;
        end
    end

endmodule
